// ===== design/c2d_pkg.sv =====
// c2d_pkg: sizes, register codes and helper functions for the 2-D convolution block.
// Used by the channel interfaces and by conv2d_zero_pad_abs_round_top.
`default_nettype none

package c2d_pkg;

  // Frame and kernel limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int KSIDE      = 4;
  localparam int TAPS       = KSIDE * KSIDE;

  // Field widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int DIM_W  = 11;
  localparam int KDIM_W = 3;
  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int BANK_W = 64;
  localparam int NBANKS = 4;
  localparam int REG_W  = 3;
  localparam int TAP_W  = $clog2(TAPS);

  // Datapath widths
  localparam int PROD_W = 24;
  localparam int PSUM_W = 26;
  localparam int SUM_W  = 28;
  localparam int MAG_W  = SUM_W - 8;
  localparam int POS_W  = 21;
  localparam int LB_W   = PIX_W * (KSIDE - 1);

  typedef enum logic [REG_W-1:0] {
    REG_IMG_W  = 3'd0,
    REG_IMG_H  = 3'd1,
    REG_KER_W  = 3'd2,
    REG_KER_H  = 3'd3,
    REG_COEF_0 = 3'd4,
    REG_COEF_1 = 3'd5,
    REG_COEF_2 = 3'd6,
    REG_COEF_3 = 3'd7
  } reg_idx_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Out-of-range sizes are pulled into the legal range
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [KDIM_W-1:0] clamp_kside(logic [KDIM_W-1:0] v);
    logic [KDIM_W-1:0] r;
    if (v == '0) r = KDIM_W'(1);
    else if (v > KDIM_W'(KSIDE)) r = KDIM_W'(KSIDE);
    else r = v;
    return r;
  endfunction

  // Tap t sits in bits 16t..16t+15 of the four banks taken together
  function automatic coef_t tap_of(logic [BANK_W*NBANKS-1:0] banks, logic [TAP_W-1:0] t);
    return coef_t'(banks[{t, 4'b0000} +: COEF_W]);
  endfunction

endpackage

`default_nettype wire

// ===== design/c2d_in_if.sv =====
// c2d_in_if: pixel input channel, valid/ready with pixel and pad flag.
// Depends on c2d_pkg.
`default_nettype none

interface c2d_in_if;
  import c2d_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             pad_beat;

  modport source (output valid, output pixel, output pad_beat, input ready);
  modport sink   (input valid, input pixel, input pad_beat, output ready);
endinterface

`default_nettype wire

// ===== design/c2d_out_if.sv =====
// c2d_out_if: result channel, valid/ready with result pixel and flags.
// Depends on c2d_pkg.
`default_nettype none

interface c2d_out_if;
  import c2d_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] result_pixel;
  logic             saturated;
  logic             frame_last;

  modport source (output valid, output result_pixel, output saturated, output frame_last,
                  input ready);
  modport sink   (input valid, input result_pixel, input saturated, input frame_last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/c2d_cfg_if.sv =====
// c2d_cfg_if: register write channel, valid/ready with index and data.
// Depends on c2d_pkg.
`default_nettype none

interface c2d_cfg_if;
  import c2d_pkg::*;
  logic              valid;
  logic              ready;
  logic [REG_W-1:0]  index;
  logic [BANK_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/c2d_ram.sv =====
// c2d_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies. A read of the address being written returns the old data.
`default_nettype none

module c2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/conv2d_zero_pad_abs_round_top.sv =====
// conv2d_zero_pad_abs_round_top: streaming zero-padded 2-D convolution, |sum| rounded
// and saturated. Depends on c2d_pkg, c2d_in_if, c2d_out_if, c2d_cfg_if, c2d_ram.
//
//  channel   dir  signals                                      transfer when
//  pixels    in   pixel[7:0], pad_beat                         valid & ready
//  results   out  result_pixel[7:0], saturated, frame_last     valid & ready
//  regs      in   index[2:0], data[63:0]                       valid & ready (ready tied high)
//
// One pixel per clock is taken while pixels.ready is high; a result passes stages 0
// to 4 after the pixel transfer that completes its window. Throughput is set by the
// single line-store RAM, read one column ahead and written in the transfer cycle. rst
// is synchronous and clears all counters and pipeline valids; the line store needs no
// clearing. A stall on results fills the pipeline bubbles first, then drops pixels.ready.
`default_nettype none

module conv2d_zero_pad_abs_round_top (
  input logic  clk,
  input logic  rst,
  c2d_in_if.sink    pixels,
  c2d_out_if.source results,
  c2d_cfg_if.sink   regs
);
  import c2d_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]         img_w_reg;
  logic [DIM_W-1:0]         img_h_reg;
  logic [KDIM_W-1:0]        ker_w_reg;
  logic [KDIM_W-1:0]        ker_h_reg;
  logic [BANK_W*NBANKS-1:0] banks;

  // Clamped sizes and derived values
  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;
  logic [KDIM_W-1:0] kw;
  logic [KDIM_W-1:0] kh;
  logic [1:0]        cx;
  logic [1:0]        cy;
  logic [POS_W-1:0]  lag;

  // Input side
  logic              cfg_we;
  logic              acc;
  logic              due;
  logic              last_now;
  logic              frame_end;
  logic              col_wrap;
  logic [COL_W-1:0]  in_column;
  logic [COL_W-1:0]  col_next;
  logic [POS_W-1:0]  pos;
  logic [COL_W-1:0]  ox;
  logic [COL_W-1:0]  oy;
  logic [PIX_W-1:0]  new_pix;

  // Line store
  logic [COL_W-1:0]  rd_addr;
  logic [LB_W-1:0]   ram_rdata;
  logic [LB_W-1:0]   lb;
  logic [LB_W-1:0]   wdata;
  logic              fwd;
  logic [LB_W-1:0]   fwd_data;

  // Window and pipeline
  logic [PIX_W-1:0]         win [KSIDE][KSIDE];
  logic [PIX_W-1:0]         col [KSIDE];
  logic [TAPS-1:0]          mask_c;
  logic                     v0, v1, v2, v3;
  logic                     rdy0, rdy1, rdy2, rdy3, rdy4;
  logic [TAPS-1:0]          mask0;
  logic                     last0, last1, last2, last3;
  logic signed [PROD_W-1:0] prod_c [TAPS];
  logic signed [PROD_W-1:0] prod1 [TAPS];
  logic signed [PSUM_W-1:0] psum_c [KSIDE];
  logic signed [PSUM_W-1:0] psum2 [KSIDE];
  logic signed [SUM_W-1:0]  sum_c;
  logic signed [SUM_W-1:0]  sum3;
  logic [SUM_W-1:0]         mag;
  logic [SUM_W-1:0]         mag_rnd;
  logic [MAG_W-1:0]         rnd;

  // Register writes
  assign cfg_we     = regs.valid;
  assign regs.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w_reg <= DIM_W'(1);
      img_h_reg <= DIM_W'(1);
      ker_w_reg <= KDIM_W'(1);
      ker_h_reg <= KDIM_W'(1);
      banks     <= (BANK_W*NBANKS)'(256);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(regs.index))
        REG_IMG_W:  img_w_reg <= regs.data[DIM_W-1:0];
        REG_IMG_H:  img_h_reg <= regs.data[DIM_W-1:0];
        REG_KER_W:  ker_w_reg <= regs.data[KDIM_W-1:0];
        REG_KER_H:  ker_h_reg <= regs.data[KDIM_W-1:0];
        REG_COEF_0: banks[0*BANK_W +: BANK_W] <= regs.data;
        REG_COEF_1: banks[1*BANK_W +: BANK_W] <= regs.data;
        REG_COEF_2: banks[2*BANK_W +: BANK_W] <= regs.data;
        REG_COEF_3: banks[3*BANK_W +: BANK_W] <= regs.data;
      endcase
    end
  end

  // Sizes; lag = cy*w + cx with cy at most 2
  assign w   = clamp_dim(img_w_reg, DIM_W'(MAX_WIDTH));
  assign h   = clamp_dim(img_h_reg, DIM_W'(MAX_HEIGHT));
  assign kw  = clamp_kside(ker_w_reg);
  assign kh  = clamp_kside(ker_h_reg);
  assign cx  = kw[2:1];
  assign cy  = kh[2:1];
  assign lag = (cy[1] ? POS_W'({w, 1'b0}) : (cy[0] ? POS_W'(w) : '0)) + POS_W'(cx);

  // Raster position and output coordinates
  assign acc       = pixels.valid && pixels.ready;
  assign due       = pos >= lag;
  assign last_now  = (DIM_W'(ox) == w - DIM_W'(1)) && (DIM_W'(oy) == h - DIM_W'(1));
  assign frame_end = acc && due && last_now;
  assign col_wrap  = (DIM_W'(in_column) + DIM_W'(1)) == w;
  assign col_next  = (frame_end || col_wrap) ? '0 : in_column + COL_W'(1);
  assign new_pix   = pixels.pad_beat ? '0 : pixels.pixel;

  always_ff @(posedge clk) begin
    if (rst || cfg_we || frame_end) begin
      in_column <= '0;
      pos       <= '0;
      ox        <= '0;
      oy        <= '0;
    end else if (acc) begin
      in_column <= col_next;
      pos       <= pos + POS_W'(1);
      if (due) begin
        if (DIM_W'(ox) == w - DIM_W'(1)) begin
          ox <= '0;
          oy <= oy + COL_W'(1);
        end else begin
          ox <= ox + COL_W'(1);
        end
      end
    end
  end

  // Line store: entry c holds column c of the three rows above; read one ahead
  assign rd_addr = cfg_we ? '0 : (acc ? col_next : in_column);
  assign lb      = fwd ? fwd_data : ram_rdata;
  assign wdata   = {lb[LB_W-PIX_W-1:0], new_pix};

  c2d_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (acc),
    .waddr (in_column),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Forward the write when the next read hits the same column
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= acc && (rd_addr == in_column);
    end
    fwd_data <= wdata;
  end

  // New column entering the window
  always_comb begin
    col[0] = new_pix;
    for (int k = 1; k < KSIDE; k++) begin
      col[k] = lb[(k-1)*PIX_W +: PIX_W];
    end
  end

  // Window registers shift one column per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < KSIDE; m++) begin
        for (int n = 0; n < KSIDE; n++) begin
          win[m][n] <= '0;
        end
      end
    end else if (acc) begin
      for (int m = 0; m < KSIDE; m++) begin
        win[m][0] <= col[m];
        for (int n = 1; n < KSIDE; n++) begin
          win[m][n] <= win[m][n-1];
        end
      end
    end
  end

  // Tap masks: kernel extent and frame borders
  always_comb begin
    logic [DIM_W:0] sy;
    logic [DIM_W:0] sx;
    sy = (DIM_W+1)'(oy) + (DIM_W+1)'(cy);
    sx = (DIM_W+1)'(ox) + (DIM_W+1)'(cx);
    for (int m = 0; m < KSIDE; m++) begin
      for (int n = 0; n < KSIDE; n++) begin
        mask_c[m*KSIDE+n] = (KDIM_W'(m) < kh) && (KDIM_W'(n) < kw)
                            && (sy >= (DIM_W+1)'(m)) && (sy - (DIM_W+1)'(m) < (DIM_W+1)'(h))
                            && (sx >= (DIM_W+1)'(n)) && (sx - (DIM_W+1)'(n) < (DIM_W+1)'(w));
      end
    end
  end

  // Pipeline handshake, bubbles collapse
  assign rdy4         = !results.valid || results.ready;
  assign rdy3         = !v3 || rdy4;
  assign rdy2         = !v2 || rdy3;
  assign rdy1         = !v1 || rdy2;
  assign rdy0         = !v0 || rdy1;
  assign pixels.ready = rdy0;

  // Stage 0: output due, masks and frame end flag
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= acc && due;
    end
    if (rdy0) begin
      mask0 <= mask_c;
      last0 <= last_now;
    end
  end

  // Products of window pixels and mapped taps
  always_comb begin
    logic signed [PIX_W+COEF_W:0] full;
    logic [4:0]                   ti;
    for (int m = 0; m < KSIDE; m++) begin
      for (int n = 0; n < KSIDE; n++) begin
        ti   = 5'(m * kw + n);
        full = $signed({1'b0, win[m][n]}) * tap_of(banks, ti[TAP_W-1:0]);
        prod_c[m*KSIDE+n] = mask0[m*KSIDE+n] ? full[PROD_W-1:0] : '0;
      end
    end
  end

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
    if (rdy1) begin
      prod1 <= prod_c;
      last1 <= last0;
    end
  end

  // Partial sums, one per kernel row
  always_comb begin
    for (int g = 0; g < KSIDE; g++) begin
      psum_c[g] = '0;
      for (int k = 0; k < KSIDE; k++) begin
        psum_c[g] = psum_c[g] + PSUM_W'(prod1[g*KSIDE+k]);
      end
    end
  end

  // Stage 2: partial sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      psum2 <= psum_c;
      last2 <= last1;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int g = 0; g < KSIDE; g++) begin
      sum_c = sum_c + SUM_W'(psum2[g]);
    end
  end

  // Stage 3: full sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      sum3  <= sum_c;
      last3 <= last2;
    end
  end

  // Magnitude, round half up, saturate
  assign mag     = sum3[SUM_W-1] ? SUM_W'(-sum3) : SUM_W'(sum3);
  assign mag_rnd = mag + SUM_W'(128);
  assign rnd     = mag_rnd[SUM_W-1:8];

  // Stage 4: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (rdy4) begin
      results.valid <= v3;
    end
    if (rdy4) begin
      results.saturated    <= rnd > MAG_W'(255);
      results.result_pixel <= (rnd > MAG_W'(255)) ? '1 : rnd[PIX_W-1:0];
      results.frame_last   <= last3;
    end
  end

  // Checks
  a_no_due_no_stage0: assert property (@(posedge clk) disable iff (rst)
    (acc && !due) |=> !v0) else $error("stage 0 loaded for a beat with no output");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    frame_end |=> (pos == '0 && ox == '0 && oy == '0 && in_column == '0))
    else $error("counters not cleared after frame end");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (rst)
    fwd |-> $past(acc)) else $error("forwarding without a preceding write");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> (v1 && $stable(last1))) else $error("stage 1 lost while stalled");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.saturated) |-> (results.result_pixel == 8'hFF))
    else $error("saturated result not at full scale");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking bench for conv2d_zero_pad_abs_round_top.
// Depends on c2d_pkg and the c2d_in_if, c2d_out_if and c2d_cfg_if channel interfaces.
`timescale 1ns / 1ps

import c2d_pkg::*;

typedef struct packed {
  logic [PIX_W-1:0] pix;
  logic             sat;
  logic             last;
} conv_out_t;

// Scoreboard: tracks register state and pixel history, predicts each output pixel
class conv_scoreboard;
  logic [DIM_W-1:0]  img_w, img_h;
  logic [KDIM_W-1:0] ker_w, ker_h;
  logic [BANK_W-1:0] bank [NBANKS];
  logic [PIX_W-1:0]  history [KSIDE*MAX_WIDTH];
  int unsigned       col, row, sent;
  conv_out_t         pending_px [$];
  int                errors;

  function new();
    img_w = 1;
    img_h = 1;
    ker_w = 1;
    ker_h = 1;
    bank[0] = 64'd256;
    for (int b = 1; b < NBANKS; b++) bank[b] = '0;
    foreach (history[i]) history[i] = '0;
    col = 0;
    row = 0;
    sent = 0;
    errors = 0;
  endfunction

  function int unsigned limit_to(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : (v > hi) ? hi : v;
  endfunction

  function int unsigned eff_w();  return limit_to(img_w, MAX_WIDTH);  endfunction
  function int unsigned eff_h();  return limit_to(img_h, MAX_HEIGHT); endfunction
  function int unsigned eff_kw(); return limit_to(ker_w, KSIDE);      endfunction
  function int unsigned eff_kh(); return limit_to(ker_h, KSIDE);      endfunction

  // beats that follow the last pixel before the final output leaves
  function int unsigned drain_len();
    return (eff_kh() >> 1) * eff_w() + (eff_kw() >> 1);
  endfunction

  // register write: any write restarts the frame
  function void write_reg(reg_idx_t idx, logic [BANK_W-1:0] d);
    case (idx)
      REG_IMG_W:  img_w = d[DIM_W-1:0];
      REG_IMG_H:  img_h = d[DIM_W-1:0];
      REG_KER_W:  ker_w = d[KDIM_W-1:0];
      REG_KER_H:  ker_h = d[KDIM_W-1:0];
      REG_COEF_0: bank[0] = d;
      REG_COEF_1: bank[1] = d;
      REG_COEF_2: bank[2] = d;
      REG_COEF_3: bank[3] = d;
      default: ;
    endcase
    col = 0;
    row = 0;
    sent = 0;
  endfunction

  // one accepted pixel-channel transfer
  function void note_pixel(logic [PIX_W-1:0] pix, logic pad);
    int unsigned w, h, kw, kh, cx, cy, total, pos, t;
    int x, y, py, px;
    longint acc, mag, r;
    logic signed [COEF_W-1:0] tap;
    conv_out_t e;
    w = eff_w();
    h = eff_h();
    kw = eff_kw();
    kh = eff_kh();
    cx = kw >> 1;
    cy = kh >> 1;
    total = w * h;
    pos = row * w + col;
    if (pos < total) history[pos % (KSIDE*MAX_WIDTH)] = pad ? '0 : pix;
    if (pos >= drain_len()) begin
      y = sent / w;
      x = sent % w;
      acc = 0;
      for (int m = 0; m < kh; m++) begin
        for (int n = 0; n < kw; n++) begin
          py = y + cy - m;
          px = x + cx - n;
          if (py >= 0 && py < h && px >= 0 && px < w) begin
            t = m * kw + n;
            tap = bank[t >> 2][(t % 4) * COEF_W +: COEF_W];
            acc += longint'(history[(py * w + px) % (KSIDE*MAX_WIDTH)]) * longint'(tap);
          end
        end
      end
      mag = (acc < 0) ? -acc : acc;
      r = (mag + 128) >>> 8;
      e.sat = (r > 255);
      e.pix = e.sat ? 8'hFF : r[PIX_W-1:0];
      e.last = (sent + 1 >= total);
      pending_px.push_back(e);
      if (e.last) begin
        col = 0;
        row = 0;
        sent = 0;
        return;
      end
      sent++;
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
  endfunction

  // one accepted result transfer
  function void check_result(logic [PIX_W-1:0] pix, logic sat, logic last);
    conv_out_t e;
    if (pending_px.size() == 0) begin
      $display("%0t: unexpected result pix=%0d sat=%0b last=%0b", $time, pix, sat, last);
      errors++;
      return;
    end
    e = pending_px.pop_front();
    if (pix !== e.pix) begin
      $display("%0t: result_pixel expected %0d got %0d", $time, e.pix, pix);
      errors++;
    end
    if (sat !== e.sat) begin
      $display("%0t: saturated expected %0b got %0b", $time, e.sat, sat);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: frame_last expected %0b got %0b", $time, e.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return pending_px.size();
  endfunction
endclass

module testbench;
  localparam int IDLE_LIMIT = 5000;
  localparam int RAND_ITEMS = 1150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  c2d_in_if  pix_ch ();
  c2d_out_if res_ch ();
  c2d_cfg_if cfg_ch ();

  conv2d_zero_pad_abs_round_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .regs    (cfg_ch)
  );

  conv_scoreboard sb = new();

  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_off = 1'b0;
  int unsigned rand_items = 0;
  int unsigned idle_cycles = 0;

  always #10 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    res_ch.ready = !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // monitors: every transfer sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(reg_idx_t'(cfg_ch.index), cfg_ch.data);
      if (pix_ch.valid && pix_ch.ready) sb.note_pixel(pix_ch.pixel, pix_ch.pad_beat);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.result_pixel, res_ch.saturated, res_ch.frame_last);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one pixel-channel transfer; called and returns at a falling edge
  task automatic send_beat(logic [PIX_W-1:0] pix, logic pad);
    if ($urandom_range(99) < send_pct) begin
      pix_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    pix_ch.valid = 1'b1;
    pix_ch.pixel = pix;
    pix_ch.pad_beat = pad;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
    rand_items++;
  endtask

  // wait until every expected result is in, then let the pipeline empty
  task automatic settle();
    pix_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [BANK_W-1:0] d);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_all(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic [KDIM_W-1:0] kw,
                         logic [KDIM_W-1:0] kh, logic [BANK_W-1:0] b0, logic [BANK_W-1:0] b1,
                         logic [BANK_W-1:0] b2, logic [BANK_W-1:0] b3);
    settle();
    write_reg(REG_IMG_W, BANK_W'(w));
    write_reg(REG_IMG_H, BANK_W'(h));
    write_reg(REG_KER_W, BANK_W'(kw));
    write_reg(REG_KER_H, BANK_W'(kh));
    write_reg(REG_COEF_0, b0);
    write_reg(REG_COEF_1, b1);
    write_reg(REG_COEF_2, b2);
    write_reg(REG_COEF_3, b3);
  endtask

  function automatic logic [PIX_W-1:0] any_pixel();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // coefficient bank: full random, small signed taps, or unit taps
  function automatic logic [BANK_W-1:0] any_bank();
    logic [BANK_W-1:0] b;
    int mode;
    mode = $urandom_range(2);
    for (int i = 0; i < 4; i++) begin
      case (mode)
        0: b[i*COEF_W +: COEF_W] = COEF_W'($urandom);
        1: b[i*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(1200)) - 600);
        default: b[i*COEF_W +: COEF_W] = 16'h0100;
      endcase
    end
    return b;
  endfunction

  // one full frame plus drain beats; noisy frames mix pad and pixel beats oddly
  task automatic run_frame(bit noisy);
    int unsigned total, drain;
    logic pad;
    total = sb.eff_w() * sb.eff_h();
    drain = sb.drain_len();
    for (int unsigned i = 0; i < total + drain; i++) begin
      if (i < total) pad = noisy && ($urandom_range(7) == 0);
      else pad = !(noisy && ($urandom_range(2) == 0));
      send_beat(any_pixel(), pad);
    end
  endtask

  initial begin
    int phase;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    pix_ch.pad_beat = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_IMG_W;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset defaults pass pixels straight through; pad inside a frame is zero
    send_beat('0, 1'b0);
    send_beat('1, 1'b0);
    send_beat(8'hA5, 1'b1);
    // rounding half up with +0.5 and -0.5, unused taps loaded but ignored
    set_all(2, 1, 1, 1, 64'hFFFF_FFFF_FFFF_0080, '1, '1, '1);
    send_beat(8'd1, 1'b0);
    send_beat(8'd3, 1'b0);
    set_all(2, 1, 1, 1, 64'h0000_0000_0000_FF80, '0, '0, '0);
    send_beat(8'd1, 1'b0);
    send_beat(8'd255, 1'b0);
    // extreme taps, saturation, pixel beats after the frame
    set_all(3, 2, 3, 3, 64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
            64'h0000_0000_0000_7FFF, '0);
    run_frame(1'b1);

    // random phases
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      case (phase % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 50; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 50; end
        default: begin send_pct = 22; stall_pct = 22; end
      endcase
      if (phase == 1) begin
        // oversize width and kernel width pulled to their limits
        set_all(11'h7FF, 1, 3'd7, 1, any_bank(), any_bank(), any_bank(), any_bank());
        run_frame(1'b0);
      end else if (phase == 2) begin
        // zero sizes pulled up to one, oversize kernel height
        set_all(0, 0, 0, 3'd5, any_bank(), any_bank(), any_bank(), any_bank());
        run_frame(1'b0);
      end else if (phase == 3) begin
        set_all(8, 6, 3, 3, any_bank(), any_bank(), any_bank(), any_bank());
        // long receiver hold-off while pixels keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
        run_frame(1'b0);
      end else begin
        set_all(DIM_W'($urandom_range(12)), DIM_W'($urandom_range(8)),
                KDIM_W'($urandom_range(7)), KDIM_W'($urandom_range(7)),
                any_bank(), any_bank(), any_bank(), any_bank());
        repeat ($urandom_range(1, 3)) run_frame($urandom_range(3) == 0);
      end
      phase++;
    end

    // drain and report
    settle();
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
